[sv/p1tf_pkg.sv]
`default_nettype none

package p1tf_pkg;

   // Framing characters of the telegram.
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Tail length limits, the CR included.
   localparam int unsigned TAIL_MIN = 5;
   localparam int unsigned TAIL_MAX = 8;

   // At most this many hex digits are taken from the tail.
   localparam logic [2:0] HEX_DIGITS_MAX = 3'd4;

   localparam int unsigned CRC_W        = 16;
   localparam int unsigned FRAME_LEN_W  = 12;
   localparam int unsigned FRAME_CNT_W  = 16;
   localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_LONG     = 3'd2,
      ST_NOHEX    = 3'd3,
      ST_MISMATCH = 3'd4,
      ST_OVERFLOW = 3'd5
   } frame_status_type;

   // One byte of CRC-16/ARC: reflected polynomial, eight shift steps.
   function automatic logic [CRC_W-1:0] crc16_arc_byte(input logic [CRC_W-1:0] crc,
                                                       input logic [7:0] data);
      logic [CRC_W-1:0] c;
      c = crc ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] data);
      logic [4:0] r;
      r = 5'd0;
      if (data >= 8'h30 && data <= 8'h39) begin
         r = {1'b1, 4'(data - 8'h30)};
      end else if (data >= 8'h61 && data <= 8'h66) begin
         r = {1'b1, 4'(data - 8'h57)};
      end else if (data >= 8'h41 && data <= 8'h46) begin
         r = {1'b1, 4'(data - 8'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[sv/p1tf_req_if.sv]
`default_nettype none

interface p1tf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[sv/p1tf_rsp_if.sv]
`default_nettype none

interface p1tf_rsp_if;
   logic                                       valid;
   logic                                       ready;
   p1tf_pkg::frame_status_type                 frame_status;
   logic [p1tf_pkg::CRC_W-1:0]                 computed_crc;
   logic [p1tf_pkg::CRC_W-1:0]                 received_crc;
   logic [p1tf_pkg::FRAME_LEN_W-1:0]           frame_length;
   logic [p1tf_pkg::FRAME_CNT_W-1:0]           good_frames;
   logic [p1tf_pkg::FRAME_CNT_W-1:0]           bad_frames;

   modport source (output valid, output frame_status, output computed_crc,
                   output received_crc, output frame_length, output good_frames,
                   output bad_frames, input ready);
   modport sink   (input valid, input frame_status, input computed_crc,
                   input received_crc, input frame_length, input good_frames,
                   input bad_frames, output ready);
endinterface

`default_nettype wire

[sv/p1_telegram_framer_crc_check.sv]
// A status item is registered from the byte that closes or overflows a frame.
// Throughput: one byte per cycle unless held off; CRC, hex parse and framing are combinational.
// The input is held off only while a status item waits and the result side is not ready.
// Reset is synchronous: it clears the framing state, the CRC, the counts and the result valid.
`default_nettype none

module p1_telegram_framer_crc_check #(
   parameter int unsigned MAX_FRAME_BYTES = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   p1tf_req_if.sink         req_if,
   p1tf_rsp_if.source       rsp_if
);
   import p1tf_pkg::*;

   localparam int unsigned    CNT_W   = $clog2(MAX_FRAME_BYTES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
   localparam int unsigned    TAIL_W  = 4;
   localparam logic [TAIL_W-1:0] TAIL_SAT = '1;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_BODY,
      PH_TAIL
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic [CRC_W-1:0]         crc_ff, crc_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in, cnt_inc;
   logic [TAIL_W-1:0]        tail_ff, tail_in;
   logic [CRC_W-1:0]         hex_ff, hex_in;
   logic [2:0]               digits_ff, digits_in;
   logic                     stopped_ff, stopped_in;
   logic [FRAME_CNT_W-1:0]   good_ff, good_in;
   logic [FRAME_CNT_W-1:0]   bad_ff, bad_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   frame_status_type         rsp_status_ff;
   logic [CRC_W-1:0]         rsp_crc_ff;
   logic [CRC_W-1:0]         rsp_recv_ff;
   logic [FRAME_LEN_W-1:0]   rsp_len_ff;
   logic [FRAME_CNT_W-1:0]   rsp_good_ff;
   logic [FRAME_CNT_W-1:0]   rsp_bad_ff;

   logic                     accept;
   logic                     emit;
   frame_status_type         status;
   logic [7:0]               rx;
   logic [4:0]               nib;

   // The output register parts the two sides: a waiting item blocks input only if it stalls.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;
   assign rx           = req_if.rx_byte;
   assign nib          = hex_nibble(rx);
   assign cnt_inc      = cnt_ff + CNT_W'(1);

   always_comb begin
      phase_in   = phase_ff;
      crc_in     = crc_ff;
      cnt_in     = cnt_ff;
      tail_in    = tail_ff;
      hex_in     = hex_ff;
      digits_in  = digits_ff;
      stopped_in = stopped_ff;
      good_in    = good_ff;
      bad_in     = bad_ff;
      emit       = 1'b0;
      status     = ST_OK;

      if (accept) begin
         if (rx == CH_SLASH) begin
            // A slash starts a frame, or silently restarts the one in progress.
            crc_in     = crc16_arc_byte('0, rx);
            cnt_in     = CNT_W'(1);
            tail_in    = '0;
            hex_in     = '0;
            digits_in  = '0;
            stopped_in = 1'b0;
            phase_in   = PH_BODY;
         end else begin
            case (phase_ff)
               PH_BODY: begin
                  crc_in = crc16_arc_byte(crc_ff, rx);
                  cnt_in = cnt_inc;
                  if (rx == CH_BANG) begin
                     phase_in = PH_TAIL;
                  end
                  if (cnt_inc == CNT_MAX) begin
                     emit   = 1'b1;
                     status = ST_OVERFLOW;
                  end
               end
               PH_TAIL: begin
                  cnt_in  = cnt_inc;
                  tail_in = (tail_ff != TAIL_SAT) ? tail_ff + TAIL_W'(1) : tail_ff;
                  if (rx == CH_CR) begin
                     emit = 1'b1;
                     if (tail_in < TAIL_W'(TAIL_MIN)) begin
                        status = ST_SHORT;
                     end else if (tail_in > TAIL_W'(TAIL_MAX)) begin
                        status = ST_LONG;
                     end else if (digits_ff == '0) begin
                        status = ST_NOHEX;
                     end else if (hex_ff != crc_ff) begin
                        status = ST_MISMATCH;
                     end else begin
                        status = ST_OK;
                     end
                  end else begin
                     if (!stopped_ff) begin
                        if (!nib[4]) begin
                           stopped_in = 1'b1;
                        end else begin
                           hex_in    = {hex_ff[CRC_W-5:0], nib[3:0]};
                           digits_in = digits_ff + 3'd1;
                           if (digits_in >= HEX_DIGITS_MAX) begin
                              stopped_in = 1'b1;
                           end
                        end
                     end
                     if (cnt_inc == CNT_MAX) begin
                        emit   = 1'b1;
                        status = ST_OVERFLOW;
                     end
                  end
               end
               default: begin
                  // Idle: everything but a slash is dropped.
               end
            endcase
         end
      end

      if (emit) begin
         phase_in = PH_IDLE;
         if (status == ST_OK) begin
            if (good_ff != '1) begin
               good_in = good_ff + FRAME_CNT_W'(1);
            end
         end else begin
            if (bad_ff != '1) begin
               bad_in = bad_ff + FRAME_CNT_W'(1);
            end
         end
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         crc_ff       <= '0;
         cnt_ff       <= '0;
         tail_ff      <= '0;
         hex_ff       <= '0;
         digits_ff    <= '0;
         stopped_ff   <= 1'b0;
         good_ff      <= '0;
         bad_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         cnt_ff       <= cnt_in;
         tail_ff      <= tail_in;
         hex_ff       <= hex_in;
         digits_ff    <= digits_in;
         stopped_ff   <= stopped_in;
         good_ff      <= good_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit) begin
         rsp_status_ff <= status;
         rsp_crc_ff    <= crc_in;
         rsp_recv_ff   <= hex_in;
         rsp_len_ff    <= FRAME_LEN_W'(cnt_in);
         rsp_good_ff   <= good_in;
         rsp_bad_ff    <= bad_in;
      end
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.frame_status = rsp_status_ff;
   assign rsp_if.computed_crc = rsp_crc_ff;
   assign rsp_if.received_crc = rsp_recv_ff;
   assign rsp_if.frame_length = rsp_len_ff;
   assign rsp_if.good_frames  = rsp_good_ff;
   assign rsp_if.bad_frames   = rsp_bad_ff;

`ifndef SYNTHESIS
   // Every status item ends the frame it reports on.
   a_emit_goes_idle: assert property (@(posedge clock) disable iff (reset)
      emit |=> (phase_ff == PH_IDLE))
      else $error("frame not closed after a status item");

   // The frame counters never step backwards.
   a_counts_monotone: assert property (@(posedge clock) disable iff (reset)
      accept |=> (good_ff >= $past(good_ff)) && (bad_ff >= $past(bad_ff)))
      else $error("frame counter decreased");

   // A good frame always carries matching CRCs.
   a_ok_crc_match: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_OK)) |-> (rsp_recv_ff == rsp_crc_ff))
      else $error("good status with differing CRCs");

   // At most one of the two counters moves per item.
   a_one_counter: assert property (@(posedge clock) disable iff (reset)
      emit |=> ((good_ff != $past(good_ff)) + (bad_ff != $past(bad_ff))) <= 2'd1)
      else $error("both frame counters changed");
`endif

endmodule

`default_nettype wire

[tb/sv/p1tf_frame_checker.sv]
`default_nettype none

module p1tf_frame_checker #(
   parameter int unsigned FRAME_LIMIT = 2048
) (
   input  wire logic  clock,
   input  wire logic  reset,
   p1tf_req_if        req_mon,
   p1tf_rsp_if        rsp_mon,
   output int unsigned mismatches,
   output int unsigned outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import p1tf_pkg::*;

   typedef enum logic [1:0] {SCAN_IDLE, SCAN_BODY, SCAN_TAIL} scan_phase_type;

   typedef struct packed {
      frame_status_type         status;
      logic [CRC_W-1:0]         crc_calc;
      logic [CRC_W-1:0]         crc_seen;
      logic [FRAME_LEN_W-1:0]   length;
      logic [FRAME_CNT_W-1:0]   good;
      logic [FRAME_CNT_W-1:0]   bad;
   } frame_verdict_type;

   frame_verdict_type        verdicts_due[$];
   scan_phase_type           phase;
   logic [CRC_W-1:0]         crc_acc;
   logic [31:0]              frame_bytes;
   logic [11:0]              tail_len;
   logic [CRC_W-1:0]         hex_acc;
   logic [2:0]               hex_count;
   logic                     hex_done;
   logic [FRAME_CNT_W-1:0]   good_total;
   logic [FRAME_CNT_W-1:0]   bad_total;
   int unsigned              fault_total;
   int unsigned              items_checked;

   // Bit-serial form of the reflected CRC: each data bit is folded in on its own.
   function automatic logic [CRC_W-1:0] arc_fold(input logic [CRC_W-1:0] acc,
                                                 input logic [7:0] data);
      logic [CRC_W-1:0] r;
      logic             fb;
      r = acc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ data[i];
         r = r >> 1;
         if (fb) begin
            r = r ^ CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic logic [4:0] hex_digit_of(input logic [7:0] ch);
      logic [7:0] off;
      if (ch >= "0" && ch <= "9") begin
         off = ch - "0";
         return {1'b1, off[3:0]};
      end
      if (ch >= "a" && ch <= "f") begin
         off = ch - "a" + 8'd10;
         return {1'b1, off[3:0]};
      end
      if (ch >= "A" && ch <= "F") begin
         off = ch - "A" + 8'd10;
         return {1'b1, off[3:0]};
      end
      return 5'd0;
   endfunction

   task automatic restart_scan();
      crc_acc = arc_fold('0, CH_SLASH);
      frame_bytes = 1;
      tail_len = '0;
      hex_acc = '0;
      hex_count = '0;
      hex_done = 1'b0;
      phase = SCAN_BODY;
   endtask

   task automatic close_frame(input frame_status_type st);
      frame_verdict_type v;
      if (st == ST_OK) begin
         if (good_total != '1) good_total++;
      end else begin
         if (bad_total != '1) bad_total++;
      end
      v.status = st;
      v.crc_calc = crc_acc;
      v.crc_seen = hex_acc;
      v.length = frame_bytes[FRAME_LEN_W-1:0];
      v.good = good_total;
      v.bad = bad_total;
      verdicts_due.push_back(v);
      phase = SCAN_IDLE;
   endtask

   task automatic take_byte(input logic [7:0] ch);
      logic [4:0] dig;
      if (ch == CH_SLASH) begin
         restart_scan();
         return;
      end
      if (phase == SCAN_IDLE) return;
      if (phase == SCAN_BODY) begin
         crc_acc = arc_fold(crc_acc, ch);
         frame_bytes++;
         if (ch == CH_BANG) phase = SCAN_TAIL;
      end else begin
         frame_bytes++;
         if (tail_len != 12'hFFF) tail_len++;
         if (ch == CH_CR) begin
            // The checks are ranked: length first, then the digits, then the value.
            if (tail_len < TAIL_MIN) close_frame(ST_SHORT);
            else if (tail_len > TAIL_MAX) close_frame(ST_LONG);
            else if (hex_count == 0) close_frame(ST_NOHEX);
            else if (hex_acc != crc_acc) close_frame(ST_MISMATCH);
            else close_frame(ST_OK);
            return;
         end
         if (!hex_done) begin
            dig = hex_digit_of(ch);
            if (!dig[4]) begin
               hex_done = 1'b1;
            end else begin
               hex_acc = {hex_acc[CRC_W-5:0], dig[3:0]};
               hex_count++;
               if (hex_count >= HEX_DIGITS_MAX) hex_done = 1'b1;
            end
         end
      end
      if (frame_bytes >= FRAME_LIMIT) close_frame(ST_OVERFLOW);
   endtask

   always @(posedge clock) begin
      frame_verdict_type want;
      frame_verdict_type seen;
      if (reset) begin
         phase = SCAN_IDLE;
         crc_acc = '0;
         frame_bytes = 0;
         tail_len = '0;
         hex_acc = '0;
         hex_count = '0;
         hex_done = 1'b0;
         good_total = '0;
         bad_total = '0;
         fault_total = 0;
         items_checked = 0;
         verdicts_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) take_byte(req_mon.rx_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.status = rsp_mon.frame_status;
            seen.crc_calc = rsp_mon.computed_crc;
            seen.crc_seen = rsp_mon.received_crc;
            seen.length = rsp_mon.frame_length;
            seen.good = rsp_mon.good_frames;
            seen.bad = rsp_mon.bad_frames;
            if (verdicts_due.size() == 0) begin
               if (fault_total < 10) begin
                  $display("status item with no frame pending: st %0d crc %h rx %h len %0d",
                           seen.status, seen.crc_calc, seen.crc_seen, seen.length);
               end
               fault_total++;
            end else begin
               want = verdicts_due.pop_front();
               if (seen !== want) begin
                  if (fault_total < 10) begin
                     $display("status item %0d: expected st %0d crc %h rx %h len %0d good %0d bad %0d",
                              items_checked, want.status, want.crc_calc, want.crc_seen,
                              want.length, want.good, want.bad);
                     $display("status item %0d:      got st %0d crc %h rx %h len %0d good %0d bad %0d",
                              items_checked, seen.status, seen.crc_calc, seen.crc_seen,
                              seen.length, seen.good, seen.bad);
                  end
                  fault_total++;
               end
            end
            items_checked++;
         end
      end
      mismatches <= fault_total;
      outstanding <= verdicts_due.size();
   end

endmodule

`default_nettype wire

[tb/sv/p1_telegram_framer_crc_check_tb.sv]
`default_nettype none

module p1_telegram_framer_crc_check_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import p1tf_pkg::*;

   localparam int unsigned FRAME_LIMIT    = 2048;
   localparam int unsigned RANDOM_BYTES   = 1650;
   localparam int unsigned HOLD_CYCLES    = 400;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES  = 8;

   typedef enum {
      FR_GOOD, FR_MISMATCH, FR_SHORT, FR_LONG, FR_NOHEX,
      FR_FEWDIGITS, FR_EXTRA_HEX, FR_ABANDON, FR_NOISE
   } frame_kind_type;

   logic        clock;
   logic        reset;
   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned hold_asks;
   int unsigned idle_cycles;
   int unsigned burst_left;
   int unsigned sent_bytes;
   logic [7:0]  frame_q[$];
   logic [15:0] frame_crc;

   p1tf_req_if req_ch ();
   p1tf_rsp_if rsp_ch ();

   p1_telegram_framer_crc_check #(
      .MAX_FRAME_BYTES (FRAME_LIMIT)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   p1tf_frame_checker #(
      .FRAME_LIMIT (FRAME_LIMIT)
   ) frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: stretches of differing stall patterns, plus one long hold-off on request.
   initial begin
      int unsigned stretch;
      int unsigned mode;
      int unsigned served;
      logic [7:0]  mask;
      stretch = 0;
      served = 0;
      mode = 0;
      mask = 8'h01;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != served) begin
            served = hold_asks;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (stretch == 0) begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(20, 300);
            mask = 8'($urandom) | 8'h01;
         end
         stretch--;
         mask = {mask[6:0], mask[7]};
         case (mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= 1'($urandom_range(0, 1));
            2: rsp_ch.ready <= mask[0];
            default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   function automatic logic [15:0] crc_after(input logic [15:0] acc, input logic [7:0] ch);
      logic [15:0] r;
      r = acc ^ {8'h00, ch};
      repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      return r;
   endfunction

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return "0" + nib;
      return (upper ? "A" : "a") + nib - 8'd10;
   endfunction

   function automatic logic [7:0] body_char();
      logic [7:0]  c;
      int unsigned r;
      r = $urandom_range(0, 99);
      do begin
         if (r < 80) c = 8'($urandom_range(8'h20, 8'h7E));
         else if (r < 88) c = $urandom_range(0, 1) ? CH_CR : 8'h0A;
         else c = 8'($urandom);
      end while (c == CH_SLASH || c == CH_BANG);
      return c;
   endfunction

   function automatic logic [7:0] tail_noise();
      logic [7:0] c;
      if ($urandom_range(0, 1) == 0) return hex_char(4'($urandom), 1'($urandom_range(0, 1)));
      do c = 8'($urandom); while (c == CH_SLASH || c == CH_CR);
      return c;
   endfunction

   function automatic logic [7:0] non_hex();
      logic [7:0] c;
      do c = 8'($urandom); while (is_hex(c) || c == CH_SLASH || c == CH_CR);
      return c;
   endfunction

   task automatic push_byte(input logic [7:0] ch);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(20, 60)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 500)
                                                  : $urandom_range(1, 24);
      end
      req_ch.valid <= 1'b1;
      req_ch.rx_byte <= ch;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      burst_left--;
      sent_bytes++;
   endtask

   task automatic open_frame();
      frame_q.delete();
      frame_q.push_back(CH_SLASH);
      frame_crc = crc_after('0, CH_SLASH);
   endtask

   task automatic add_body(input logic [7:0] ch);
      frame_q.push_back(ch);
      frame_crc = crc_after(frame_crc, ch);
   endtask

   task automatic add_tail(input logic [7:0] ch);
      frame_q.push_back(ch);
   endtask

   // Appends the top 'count' nibbles of value as hex, each in a random case.
   task automatic add_digits(input logic [15:0] value, input int count);
      for (int i = 0; i < count; i++)
         add_tail(hex_char(value[15-4*i -: 4], 1'($urandom_range(0, 1))));
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++) push_byte(frame_q[i]);
   endtask

   function automatic int pick_body_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(0, 20);
      if (r < 97) return $urandom_range(21, 60);
      return $urandom_range(150, 300);
   endfunction

   task automatic build_frame(input frame_kind_type kind, input int body_len);
      int          n;
      logic [15:0] wrong;
      open_frame();
      repeat (body_len) add_body(body_char());
      add_body(CH_BANG);
      case (kind)
         FR_GOOD: add_digits(frame_crc, 4);
         FR_MISMATCH: begin
            wrong = 16'($urandom_range(1, 65535));
            add_digits(frame_crc ^ wrong, 4);
         end
         FR_SHORT: repeat ($urandom_range(0, 3)) add_tail(tail_noise());
         FR_LONG: begin
            add_digits(frame_crc, 4);
            repeat ($urandom_range(4, 12)) add_tail(tail_noise());
         end
         FR_NOHEX: begin
            add_tail(non_hex());
            repeat ($urandom_range(3, 6)) add_tail(tail_noise());
         end
         FR_FEWDIGITS: begin
            // Low digits of the true CRC, cut short by a non-hex byte.
            n = $urandom_range(1, 3);
            add_digits(frame_crc << (4 * (4 - n)), n);
            add_tail(non_hex());
            repeat (3 - n) add_tail(tail_noise());
         end
         default: begin
            add_digits(frame_crc, 4);
            repeat ($urandom_range(1, 3))
               add_tail(hex_char(4'($urandom), 1'($urandom_range(0, 1))));
         end
      endcase
      add_tail(CH_CR);
   endtask

   // Frames that hit the byte limit: in the body, in the tail, and closed by CR on the limit.
   task automatic build_oversize(input int variant);
      open_frame();
      if (variant == 0) begin
         while (frame_q.size() < FRAME_LIMIT - 1) add_body(body_char());
         add_body($urandom_range(0, 1) ? CH_BANG : body_char());
      end else begin
         repeat ($urandom_range(0, 40)) add_body(body_char());
         add_body(CH_BANG);
         add_digits(frame_crc, $urandom_range(0, 4));
         while (frame_q.size() < FRAME_LIMIT - variant + 1) add_tail(tail_noise());
         if (variant == 2) add_tail(CH_CR);
      end
   endtask

   initial begin
      frame_kind_type kind;
      int unsigned r;
      int unsigned random_start;
      int unsigned frame_count;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      burst_left = 0;
      hold_asks = 0;
      sent_bytes = 0;
      frame_count = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Bytes outside a frame are dropped without a result.
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CH_BANG);
      push_byte(CH_CR);
      // Shortest well-formed frame.
      open_frame();
      add_body(CH_BANG);
      add_digits(frame_crc, 4);
      add_tail(CH_CR);
      send_frame();
      // Bare tail: too short.
      open_frame();
      add_body(CH_BANG);
      add_tail(CH_CR);
      send_frame();
      // A slash mid-frame restarts it; the CR that follows is plain body data.
      push_byte(CH_SLASH);
      push_byte("x");
      open_frame();
      add_body(CH_CR);
      add_body(CH_BANG);
      add_digits(frame_crc, 4);
      add_tail(CH_CR);
      send_frame();

      for (int i = 0; i < 3; i++) begin
         build_oversize(i);
         send_frame();
      end

      random_start = sent_bytes;
      while (sent_bytes - random_start < RANDOM_BYTES) begin
         frame_count++;
         if (frame_count == 12) hold_asks++;
         r = $urandom_range(0, 99);
         if (r < 32) kind = FR_GOOD;
         else if (r < 42) kind = FR_MISMATCH;
         else if (r < 50) kind = FR_SHORT;
         else if (r < 58) kind = FR_LONG;
         else if (r < 66) kind = FR_NOHEX;
         else if (r < 74) kind = FR_FEWDIGITS;
         else if (r < 82) kind = FR_EXTRA_HEX;
         else if (r < 90) kind = FR_ABANDON;
         else kind = FR_NOISE;
         if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
         end else if (kind == FR_ABANDON) begin
            open_frame();
            repeat (pick_body_len()) add_body(body_char());
            if ($urandom_range(0, 1)) begin
               add_body(CH_BANG);
               repeat ($urandom_range(0, 3)) add_tail(tail_noise());
            end
            send_frame();
         end else begin
            build_frame(kind, pick_body_len());
            send_frame();
         end
      end

      req_ch.valid <= 1'b0;
      // The checker's count only takes in the last accepted byte after this edge.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire
